// ----- rtl/core/edri_pkg.sv -----
`default_nettype none

package edri_pkg;

	localparam int P_W    = 21;
	localparam int RAW_W  = 22;
	localparam int ROOT_W = 17;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int MS_W   = 10;
	localparam int INT_W  = 40;
	localparam int IVL_W  = 20;
	localparam int ERR_W  = 16;
	localparam int FRAC_SH = 12;

	localparam int CFG_DW  = 32;
	localparam int CFG_AW  = 4;
	localparam int REGIX_W = 2;

	localparam int CONSEC_DEF = 3;
	localparam int NOM_MS_DEF = 100;

	localparam logic [REGIX_W-1:0] REG_ZERO_OFFSET = 2'd0;
	localparam logic [REGIX_W-1:0] REG_START_TH    = 2'd1;
	localparam logic [REGIX_W-1:0] REG_STOP_TH     = 2'd2;

	localparam logic [P_W-1:0] START_TH_RST = 21'd1024;
	localparam logic [P_W-1:0] STOP_TH_RST  = 21'd492;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef struct packed {
		logic signed [P_W-1:0] zero_offset;
		logic [P_W-1:0]        start_th;
		logic [P_W-1:0]        stop_th;
	} edri_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_MUL,
		ST_UPD
	} edri_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/edri_in_if.sv -----
`default_nettype none

interface edri_in_if
	import edri_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic                    sample_valid;
	logic signed [RAW_W-1:0] raw_pressure;
	logic [MS_W-1:0]         elapsed_ms;

	modport source (
		output valid, action, sample_valid, raw_pressure, elapsed_ms,
		input  ready
	);
	modport sink (
		input  valid, action, sample_valid, raw_pressure, elapsed_ms,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/edri_out_if.sv -----
`default_nettype none

interface edri_out_if
	import edri_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              exhaling;
	logic              breath_started;
	logic              breath_ended;
	logic [P_W-1:0]    zeroed_pressure;
	logic [ROOT_W-1:0] pressure_root;
	logic [INT_W-1:0]  breath_integral;
	logic [IVL_W-1:0]  breath_interval_ms;
	logic [ERR_W-1:0]  error_count;

	modport source (
		output valid, exhaling, breath_started, breath_ended, zeroed_pressure,
		       pressure_root, breath_integral, breath_interval_ms, error_count,
		input  ready
	);
	modport sink (
		input  valid, exhaling, breath_started, breath_ended, zeroed_pressure,
		       pressure_root, breath_integral, breath_interval_ms, error_count,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/edri_cfg.sv -----
`default_nettype none

module edri_cfg
	import edri_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready,
	output edri_cfg_t              cfg
);

	edri_cfg_t           cfg_q;
	logic [REGIX_W-1:0]  reg_ix;
	logic                wr_en;

	assign pready = 1'b1;
	assign reg_ix = paddr[CFG_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset <= '0;
			cfg_q.start_th    <= START_TH_RST;
			cfg_q.stop_th     <= STOP_TH_RST;
		end else if (wr_en) begin
			unique case (reg_ix)
				REG_ZERO_OFFSET: cfg_q.zero_offset <= $signed(pwdata[P_W-1:0]);
				REG_START_TH:    cfg_q.start_th    <= pwdata[P_W-1:0];
				REG_STOP_TH:     cfg_q.stop_th     <= pwdata[P_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_ix)
			REG_ZERO_OFFSET: prdata = {{(CFG_DW-P_W){cfg_q.zero_offset[P_W-1]}},
			                           cfg_q.zero_offset};
			REG_START_TH:    prdata = CFG_DW'(cfg_q.start_th);
			REG_STOP_TH:     prdata = CFG_DW'(cfg_q.stop_th);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/edri_root.sv -----
`default_nettype none

// restoring square root, two radicand bits per cycle
module edri_root
	import edri_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  busy,
	output logic [ROOT_W-1:0]     root
);

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign busy   = busy_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/exhale_detect_root_integrator.sv -----
// Flow: an accepted valid sample goes through 17 root steps, a state to see the
// root unit done, one multiply and one update, and its result is registered at
// the output; invalid samples and clear commands go straight to the update.
// The block takes no new item until the update of the last one is done;
// a held result stalls the next item.
// Reset (arst_n, asynchronous): registers to defaults, all breath state cleared.
`default_nettype none

module exhale_detect_root_integrator
	import edri_pkg::*;
#(
	parameter int CONSECUTIVE_SAMPLES = CONSEC_DEF,
	parameter int NOMINAL_INTERVAL_MS = NOM_MS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	edri_in_if.sink                in_item,
	edri_out_if.source             out_item,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready
);

	localparam int N      = CONSECUTIVE_SAMPLES;
	localparam int SUM_W  = ROOT_W + $clog2(N + 1);
	localparam int PROD_W = SUM_W + MS_W;
	localparam logic [MS_W-1:0] NOM_MS = MS_W'(NOMINAL_INTERVAL_MS);

	edri_cfg_t   cfg;
	edri_state_t state_q, state_d;

	logic in_ready, accept, root_load, mul_en, commit, root_busy;
	logic [ROOT_W-1:0] root;

	// accepted item
	logic            clear_q, valid_q;
	logic [MS_W-1:0] ms_q;
	logic [P_W-1:0]  p_q;

	// breath state
	logic [P_W-1:0]    pres_hist_q [N];
	logic [ROOT_W-1:0] root_hist_q [N];
	logic [SUM_W-1:0]  hsum_q;
	logic              in_exhale_q, seen_q;
	logic [IVL_W-1:0]  icnt_q, last_int_q;
	logic [INT_W-1:0]  integral_q;
	logic [ERR_W-1:0]  fault_q;
	logic [PROD_W-1:0] prod_q;

	// output register
	logic              out_valid_q;
	logic              exh_out_q, start_out_q, end_out_q;
	logic [P_W-1:0]    zp_out_q;
	logic [ROOT_W-1:0] root_out_q;
	logic [INT_W-1:0]  integral_out_q;
	logic [IVL_W-1:0]  ivl_out_q;
	logic [ERR_W-1:0]  err_out_q;

	logic signed [P_W+1:0] diff;
	logic [P_W-1:0]        p_in;
	logic [SUM_W-1:0]      mul_a;
	logic [MS_W-1:0]       mul_b;

	logic [P_W-1:0]    p_cur;
	logic [ROOT_W-1:0] r_cur;
	logic              stop_all, start_all, started_d, ended_d, in_exhale_d, seen_d;
	logic [IVL_W:0]    icnt_sum;
	logic [IVL_W-1:0]  icnt_d, last_int_d;
	logic [INT_W-1:0]  acc_base, integral_d;
	logic [INT_W:0]    acc_sum;
	logic [ERR_W-1:0]  fault_d;
	logic [SUM_W-1:0]  hsum_d;

	edri_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	edri_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (root_load),
		.radicand (RAD_W'({p_in, {FRAC_SH{1'b0}}})),
		.busy     (root_busy),
		.root     (root)
	);

	// offset and clamp
	assign diff = $signed({in_item.raw_pressure[RAW_W-1], in_item.raw_pressure})
	            - $signed({{2{cfg.zero_offset[P_W-1]}}, cfg.zero_offset});
	assign p_in = diff[P_W+1] ? '0 : (diff[P_W] ? '1 : diff[P_W-1:0]);

	assign accept = in_item.valid && in_ready;
	assign in_item.ready = in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.action == ACT_CLEAR || !in_item.sample_valid) begin
						state_d = ST_UPD;
					end else begin
						state_d = ST_ROOT;
					end
				end
			end
			ST_ROOT: begin
				if (!root_busy) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_UPD;
			ST_UPD: begin
				if (!out_valid_q || out_item.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		root_load = 1'b0;
		mul_en    = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				root_load = in_item.valid && in_item.action == ACT_SAMPLE
				            && in_item.sample_valid;
			end
			ST_MUL:  mul_en = 1'b1;
			ST_UPD:  commit = !out_valid_q || out_item.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clear_q <= in_item.action == ACT_CLEAR;
			valid_q <= in_item.sample_valid;
			ms_q    <= in_item.elapsed_ms;
			p_q     <= p_in;
		end
	end

	// shared multiplier: root * ms while exhaling, seed sum * nominal otherwise
	assign mul_a = in_exhale_q ? SUM_W'(root) : SUM_W'(root) + hsum_q;
	assign mul_b = in_exhale_q ? ms_q : NOM_MS;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	always_comb begin
		p_cur = valid_q ? p_q : pres_hist_q[0];
		r_cur = valid_q ? root : root_hist_q[0];

		stop_all  = p_q <= cfg.stop_th;
		start_all = p_q >= cfg.start_th;
		for (int i = 0; i < N - 1; i++) begin
			if (pres_hist_q[i] > cfg.stop_th) begin
				stop_all = 1'b0;
			end
			if (pres_hist_q[i] < cfg.start_th) begin
				start_all = 1'b0;
			end
		end

		icnt_sum = {1'b0, icnt_q} + (IVL_W+1)'(ms_q);
		icnt_d   = icnt_sum[IVL_W] ? '1 : icnt_sum[IVL_W-1:0];

		acc_base = in_exhale_q ? integral_q : '0;
		acc_sum  = {1'b0, acc_base} + (INT_W+1)'(prod_q);

		started_d   = 1'b0;
		ended_d     = 1'b0;
		in_exhale_d = in_exhale_q;
		seen_d      = seen_q;
		last_int_d  = last_int_q;
		integral_d  = integral_q;
		fault_d     = fault_q;
		hsum_d      = hsum_q + SUM_W'(r_cur) - SUM_W'(root_hist_q[N-1]);

		if (clear_q) begin
			in_exhale_d = 1'b0;
			seen_d      = 1'b0;
			icnt_d      = '0;
			last_int_d  = '0;
			hsum_d      = '0;
		end else if (!valid_q) begin
			fault_d = fault_q + 1'b1;
		end else if (in_exhale_q) begin
			integral_d = acc_sum[INT_W] ? '1 : acc_sum[INT_W-1:0];
			if (stop_all) begin
				in_exhale_d = 1'b0;
				ended_d     = 1'b1;
			end
		end else if (start_all) begin
			integral_d = acc_sum[INT_W] ? '1 : acc_sum[INT_W-1:0];
			if (seen_q) begin
				last_int_d = icnt_d;
			end
			seen_d      = 1'b1;
			icnt_d      = '0;
			in_exhale_d = 1'b1;
			started_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				pres_hist_q[i] <= '0;
				root_hist_q[i] <= '0;
			end
			hsum_q      <= '0;
			in_exhale_q <= 1'b0;
			seen_q      <= 1'b0;
			icnt_q      <= '0;
			last_int_q  <= '0;
			integral_q  <= '0;
			fault_q     <= '0;
		end else if (commit) begin
			for (int i = 1; i < N; i++) begin
				pres_hist_q[i] <= clear_q ? '0 : pres_hist_q[i-1];
				root_hist_q[i] <= clear_q ? '0 : root_hist_q[i-1];
			end
			pres_hist_q[0] <= clear_q ? '0 : p_cur;
			root_hist_q[0] <= clear_q ? '0 : r_cur;
			hsum_q      <= hsum_d;
			in_exhale_q <= in_exhale_d;
			seen_q      <= seen_d;
			icnt_q      <= icnt_d;
			last_int_q  <= last_int_d;
			integral_q  <= integral_d;
			fault_q     <= fault_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			exh_out_q      <= in_exhale_d;
			start_out_q    <= started_d;
			end_out_q      <= ended_d;
			zp_out_q       <= clear_q ? '0 : p_cur;
			root_out_q     <= clear_q ? '0 : r_cur;
			integral_out_q <= integral_d;
			ivl_out_q      <= last_int_d;
			err_out_q      <= fault_d;
		end
	end

	assign out_item.valid              = out_valid_q;
	assign out_item.exhaling           = exh_out_q;
	assign out_item.breath_started     = start_out_q;
	assign out_item.breath_ended       = end_out_q;
	assign out_item.zeroed_pressure    = zp_out_q;
	assign out_item.pressure_root      = root_out_q;
	assign out_item.breath_integral    = integral_out_q;
	assign out_item.breath_interval_ms = ivl_out_q;
	assign out_item.error_count        = err_out_q;

`ifndef SYNTHESIS
	a_idle_root: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !root_busy)
		else $error("root unit busy while taking input");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("result lost after update");

	a_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(start_out_q && end_out_q))
		else $error("start and end in one beat");

	a_start_exh: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && start_out_q) |-> exh_out_q)
		else $error("breath start without exhale");
`endif

endmodule

`default_nettype wire
